>>> rtl/ipthp_pkg.sv
// ipthp_pkg: request and result types, header constants and walker types
// for the ip transport header parser; no dependencies
package ipthp_pkg;

  // one request: a packet byte with its family and end mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] family;
    logic       last_byte;
  } ipthp_req_t;

  // one result per packet
  typedef struct packed {
    logic [1:0]  status;
    logic        is_ipv6;
    logic [15:0] total_length;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic        is_fragment;
    logic [15:0] fragment_word;
    logic [7:0]  protocol;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  tcp_flag_bits;
  } ipthp_rsp_t;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_RUNT = 2'd2;

  // address families
  localparam logic [1:0] FAM_V4 = 2'd0;
  localparam logic [1:0] FAM_V6 = 2'd1;

  // ip versions
  localparam logic [3:0] IPV4_VER = 4'd4;
  localparam logic [3:0] IPV6_VER = 4'd6;

  // next header / protocol numbers
  localparam logic [7:0] NH_HOP    = 8'd0;
  localparam logic [7:0] NH_ROUTE  = 8'd43;
  localparam logic [7:0] NH_FRAG   = 8'd44;
  localparam logic [7:0] NH_DSTOPT = 8'd60;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // header sizes and byte offsets
  localparam int unsigned V4_MIN_HDR     = 20;
  localparam int unsigned V6_HDR         = 40;
  localparam int unsigned V6_NH_POS      = 6;
  localparam int unsigned FRAG_HDR_BYTES = 8;
  localparam int unsigned FRAG_OFF_POS   = 2;
  localparam int unsigned TCP_MIN        = 20;
  localparam int unsigned UDP_MIN        = 8;
  localparam int unsigned TP_SPORT       = 0;
  localparam int unsigned TP_DPORT       = 2;
  localparam int unsigned TP_FLAGS       = 13;

  // ipv6 extension walker phase
  typedef enum logic [2:0] {
    WALK_BASE,
    WALK_EXT,
    WALK_FRAG,
    WALK_XPORT,
    WALK_LATER
  } walk_phase_e;

  // walker view of the packet after the current byte
  typedef struct packed {
    walk_phase_e phase;
    logic [7:0]  nxt;
    logic        frag;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  flags;
    logic        short_tcp;
    logic        short_udp;
  } walk_sum_t;

endpackage

>>> rtl/ipthp_v6_walk.sv
// ipthp_v6_walk: byte-serial walker over the ipv6 fixed and extension headers
// depends on ipthp_pkg
module ipthp_v6_walk
  import ipthp_pkg::*;
#(
  parameter int unsigned PosW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic            clear_i,
  input  logic [PosW-1:0] pos_i,
  input  logic [7:0]      data_i,
  input  logic [PosW-1:0] cap_i,
  output walk_sum_t       sum_o
);

  localparam int unsigned CmpW = (PosW > 11) ? PosW : 11;

  walk_phase_e     phase_q, phase_d;
  logic [7:0]      nxt_q, nxt_d;
  logic [7:0]      nnx_q, nnx_d;
  logic [7:0]      len_q, len_d;
  logic [7:0]      flg_q, flg_d;
  logic [PosW-1:0] hs_q, hs_d;
  logic [15:0]     foff_q, foff_d;
  logic [15:0]     sp_q, sp_d;
  logic [15:0]     dp_q, dp_d;
  logic            frag_q, frag_d;
  logic [PosW-1:0] rel, pos_nx, rem;
  logic [CmpW-1:0] rel_x, ext_last;
  logic            take_nx;
  logic [7:0]      nx_sel;

  function automatic walk_phase_e enter_hdr(logic [7:0] nh);
    walk_phase_e ph;
    if (nh == NH_HOP || nh == NH_ROUTE || nh == NH_DSTOPT) begin
      ph = WALK_EXT;
    end else if (nh == NH_FRAG) begin
      ph = WALK_FRAG;
    end else begin
      ph = WALK_XPORT;
    end
    return ph;
  endfunction

  // offset inside the current header
  assign rel      = pos_i - hs_q;
  assign pos_nx   = pos_i + 1'b1;
  assign rel_x    = CmpW'(rel);
  assign ext_last = CmpW'({len_q, 3'b111});

  // next phase
  always_comb begin
    take_nx = 1'b0;
    nx_sel  = nnx_q;
    phase_d = phase_q;
    if (step_i) begin
      case (phase_q)
        WALK_BASE: begin
          if (pos_i == PosW'(V6_HDR - 1)) begin
            take_nx = 1'b1;
            nx_sel  = nxt_q;
          end
        end
        WALK_EXT: begin
          if (rel_x == ext_last) begin
            take_nx = 1'b1;
          end
        end
        WALK_FRAG: begin
          if (rel == PosW'(FRAG_HDR_BYTES - 1)) begin
            if (foff_q[15:3] != '0) begin
              phase_d = WALK_LATER;
            end else begin
              take_nx = 1'b1;
            end
          end
        end
        default: ;
      endcase
      if (take_nx) begin
        phase_d = enter_hdr(nx_sel);
      end
    end
  end

  // header fields
  always_comb begin
    nxt_d  = nxt_q;
    nnx_d  = nnx_q;
    len_d  = len_q;
    hs_d   = hs_q;
    foff_d = foff_q;
    frag_d = frag_q;
    sp_d   = sp_q;
    dp_d   = dp_q;
    flg_d  = flg_q;
    if (step_i) begin
      case (phase_q)
        WALK_BASE: begin
          if (pos_i == PosW'(V6_NH_POS)) nxt_d = data_i;
        end
        WALK_EXT: begin
          if (rel == '0) nnx_d = data_i;
          if (rel == PosW'(1)) len_d = data_i;
        end
        WALK_FRAG: begin
          if (rel == '0) nnx_d = data_i;
          if (rel == PosW'(FRAG_OFF_POS)) foff_d[15:8] = data_i;
          if (rel == PosW'(FRAG_OFF_POS + 1)) foff_d[7:0] = data_i;
        end
        WALK_XPORT: begin
          if (rel == PosW'(TP_SPORT)) sp_d[15:8] = data_i;
          if (rel == PosW'(TP_SPORT + 1)) sp_d[7:0] = data_i;
          if (rel == PosW'(TP_DPORT)) dp_d[15:8] = data_i;
          if (rel == PosW'(TP_DPORT + 1)) dp_d[7:0] = data_i;
          if (rel == PosW'(TP_FLAGS)) flg_d = data_i;
        end
        default: ;
      endcase
      if (take_nx) begin
        nxt_d = nx_sel;
        hs_d  = pos_nx;
        if (nx_sel == NH_FRAG) frag_d = 1'b1;
      end
    end
  end

  assign rem = cap_i - hs_d;

  always_comb begin
    sum_o.phase     = phase_d;
    sum_o.nxt       = nxt_d;
    sum_o.frag      = frag_d;
    sum_o.src_port  = sp_d;
    sum_o.dst_port  = dp_d;
    sum_o.flags     = flg_d;
    sum_o.short_tcp = rem < PosW'(TCP_MIN);
    sum_o.short_udp = rem < PosW'(UDP_MIN);
  end

  // cleared at reset and at every packet end, so unseen bytes read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= WALK_BASE;
      nxt_q   <= '0;
      nnx_q   <= '0;
      len_q   <= '0;
      hs_q    <= '0;
      foff_q  <= '0;
      frag_q  <= 1'b0;
      sp_q    <= '0;
      dp_q    <= '0;
      flg_q   <= '0;
    end else if (clear_i) begin
      phase_q <= WALK_BASE;
      nxt_q   <= '0;
      nnx_q   <= '0;
      len_q   <= '0;
      hs_q    <= '0;
      foff_q  <= '0;
      frag_q  <= 1'b0;
      sp_q    <= '0;
      dp_q    <= '0;
      flg_q   <= '0;
    end else begin
      phase_q <= phase_d;
      nxt_q   <= nxt_d;
      nnx_q   <= nnx_d;
      len_q   <= len_d;
      hs_q    <= hs_d;
      foff_q  <= foff_d;
      frag_q  <= frag_d;
      sp_q    <= sp_d;
      dp_q    <= dp_d;
      flg_q   <= flg_d;
    end
  end

`ifndef SYNTHESIS
  a_hs_behind_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != WALK_BASE) |-> (hs_q <= pos_i))
    else $error("header start ahead of byte position");

  a_frag_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == WALK_FRAG || phase_q == WALK_LATER) |-> frag_q)
    else $error("fragment header walked without fragment flag");

  a_later_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == WALK_LATER && !clear_i) |=> (phase_q == WALK_LATER))
    else $error("walk resumed after a later fragment");

  a_base_exit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == WALK_BASE && !clear_i && phase_d != WALK_BASE)
      |-> (pos_i == PosW'(V6_HDR - 1)))
    else $error("fixed header left early");
`endif

endmodule

>>> rtl/ip_transport_header_parser_core.sv
// the request holding the last byte waits in the input register, and its result is written to the output register
// throughput: one byte per cycle; a last byte waits only while an untaken result is held
// the byte stream is parsed on the fly, fixed fields are captured by position, ipv6
// extension headers are walked by ipthp_v6_walk, so no packet store is needed
// reset (async, active low) clears valid flags, byte counter and all captured fields
// ip_transport_header_parser_core: top level, depends on ipthp_pkg and ipthp_v6_walk
module ip_transport_header_parser_core
  import ipthp_pkg::*;
#(
  parameter int unsigned MAX_CAPTURE_BYTES = 65535
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  ipthp_req_t in_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output ipthp_rsp_t out_rsp_o
);

  localparam int unsigned PosW = $clog2(MAX_CAPTURE_BYTES + 1);
  localparam int unsigned ExtW = PosW + 1;
  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_CAPTURE_BYTES);

  // ipv4 field positions
  localparam int unsigned P4_TOT   = 2;
  localparam int unsigned P4_FRAG  = 6;
  localparam int unsigned P4_PROTO = 9;
  localparam int unsigned P4_SRC   = 12;
  localparam int unsigned P4_DST   = 16;

  // input register
  ipthp_req_t in_q;
  logic       in_valid_q;

  // output register
  ipthp_rsp_t out_q, rsp_d;
  logic       out_valid_q;

  // handshake and byte counter
  logic            out_free, in_adv, take, is_last;
  logic [PosW-1:0] cnt_q, cnt_d, cap_d;

  // ipv4 capture
  logic [7:0]      b0_q, b0_d, prot_q, prot_d, flg4_q, flg4_d;
  logic [15:0]     tot_q, tot_d, off_q, off_d, sp4_q, sp4_d, dp4_q, dp4_d;
  logic [31:0]     src_q, src_d, dst_q, dst_d;
  logic [5:0]      hl_cur;
  logic [PosW-1:0] base4, rel4;
  logic [7:0]      data;

  // result side
  walk_sum_t       walk;
  logic [ExtW-1:0] cap_x, hlen_x;
  logic            v4_bad, v6_bad, v4_frag;

  // the request moves on unless it closes a packet and the result slot is busy
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_adv     = in_valid_q && (!in_q.last_byte || out_free);
  assign in_ready_o = !in_valid_q || in_adv;
  assign is_last    = in_adv && in_q.last_byte;
  // bytes past the capture limit are dropped
  assign take       = in_adv && (cnt_q < MaxPos);
  assign cap_d      = take ? cnt_q + 1'b1 : cnt_q;
  assign data       = in_q.data_byte;

  always_comb begin
    cnt_d = cnt_q;
    if (is_last) begin
      cnt_d = '0;
    end else if (take) begin
      cnt_d = cap_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_req_i;
    end
  end

  // transport base from the ihl nibble, taken from the current byte at position zero
  assign hl_cur = (cnt_q == '0) ? {data[3:0], 2'b00} : {b0_q[3:0], 2'b00};
  assign base4  = PosW'(hl_cur);
  assign rel4   = cnt_q - base4;

  // ipv4 fields by position; the transport window may overlap the ip header
  always_comb begin
    b0_d   = b0_q;
    tot_d  = tot_q;
    off_d  = off_q;
    prot_d = prot_q;
    src_d  = src_q;
    dst_d  = dst_q;
    sp4_d  = sp4_q;
    dp4_d  = dp4_q;
    flg4_d = flg4_q;
    if (take) begin
      case (cnt_q)
        PosW'(0):             b0_d         = data;
        PosW'(P4_TOT):        tot_d[15:8]  = data;
        PosW'(P4_TOT + 1):    tot_d[7:0]   = data;
        PosW'(P4_FRAG):       off_d[15:8]  = data;
        PosW'(P4_FRAG + 1):   off_d[7:0]   = data;
        PosW'(P4_PROTO):      prot_d       = data;
        PosW'(P4_SRC):        src_d[31:24] = data;
        PosW'(P4_SRC + 1):    src_d[23:16] = data;
        PosW'(P4_SRC + 2):    src_d[15:8]  = data;
        PosW'(P4_SRC + 3):    src_d[7:0]   = data;
        PosW'(P4_DST):        dst_d[31:24] = data;
        PosW'(P4_DST + 1):    dst_d[23:16] = data;
        PosW'(P4_DST + 2):    dst_d[15:8]  = data;
        PosW'(P4_DST + 3):    dst_d[7:0]   = data;
        default: ;
      endcase
      if (cnt_q >= base4) begin
        if (rel4 == PosW'(TP_SPORT)) sp4_d[15:8] = data;
        if (rel4 == PosW'(TP_SPORT + 1)) sp4_d[7:0] = data;
        if (rel4 == PosW'(TP_DPORT)) dp4_d[15:8] = data;
        if (rel4 == PosW'(TP_DPORT + 1)) dp4_d[7:0] = data;
        if (rel4 == PosW'(TP_FLAGS)) flg4_d = data;
      end
    end
  end

  // captured fields restart at zero for each packet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      b0_q   <= '0;
      tot_q  <= '0;
      off_q  <= '0;
      prot_q <= '0;
      src_q  <= '0;
      dst_q  <= '0;
      sp4_q  <= '0;
      dp4_q  <= '0;
      flg4_q <= '0;
    end else if (is_last) begin
      cnt_q  <= cnt_d;
      b0_q   <= '0;
      tot_q  <= '0;
      off_q  <= '0;
      prot_q <= '0;
      src_q  <= '0;
      dst_q  <= '0;
      sp4_q  <= '0;
      dp4_q  <= '0;
      flg4_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      b0_q   <= b0_d;
      tot_q  <= tot_d;
      off_q  <= off_d;
      prot_q <= prot_d;
      src_q  <= src_d;
      dst_q  <= dst_d;
      sp4_q  <= sp4_d;
      dp4_q  <= dp4_d;
      flg4_q <= flg4_d;
    end
  end

  // ipv6 walk runs alongside; the family is only known at the last byte
  ipthp_v6_walk #(
    .PosW (PosW)
  ) u_v6_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (take),
    .clear_i (is_last),
    .pos_i   (cnt_q),
    .data_i  (data),
    .cap_i   (cap_d),
    .sum_o   (walk)
  );

  // result from the state that includes the closing byte
  assign cap_x   = ExtW'(cap_d);
  assign hlen_x  = ExtW'({b0_d[3:0], 2'b00});
  assign v4_bad  = (cap_d < PosW'(V4_MIN_HDR)) || (cap_x < hlen_x) || (b0_d[7:4] != IPV4_VER);
  assign v6_bad  = (cap_d < PosW'(V6_HDR)) || (b0_d[7:4] != IPV6_VER);
  assign v4_frag = off_d[13:0] != '0;

  always_comb begin
    rsp_d         = '0;
    rsp_d.is_ipv6 = in_q.family == FAM_V6;
    case (in_q.family)
      FAM_V4: begin
        rsp_d.total_length   = tot_d;
        rsp_d.source_address = src_d;
        rsp_d.dest_address   = dst_d;
        rsp_d.is_fragment    = v4_frag;
        rsp_d.fragment_word  = (off_d[12:0] != '0) ? off_d : '0;
        rsp_d.protocol       = prot_d;
        if (prot_d == PROTO_TCP) begin
          rsp_d.source_port   = sp4_d;
          rsp_d.dest_port     = dp4_d;
          rsp_d.tcp_flag_bits = flg4_d;
          if (cap_x < hlen_x + ExtW'(TCP_MIN) && !v4_frag) rsp_d.status = ST_RUNT;
        end else if (prot_d == PROTO_UDP) begin
          rsp_d.source_port = sp4_d;
          rsp_d.dest_port   = dp4_d;
          if (cap_x < hlen_x + ExtW'(UDP_MIN) && !v4_frag) rsp_d.status = ST_RUNT;
        end
        if (v4_bad) rsp_d.status = ST_BAD;
      end
      FAM_V6: begin
        rsp_d.is_fragment = walk.frag;
        rsp_d.protocol    = walk.nxt;
        case (walk.phase)
          // extension or fragment header cut short
          WALK_EXT, WALK_FRAG: rsp_d.status = ST_RUNT;
          // later fragment, transport not present
          WALK_LATER:          rsp_d.status = ST_OK;
          WALK_XPORT: begin
            if (walk.nxt == PROTO_TCP) begin
              rsp_d.source_port   = walk.src_port;
              rsp_d.dest_port     = walk.dst_port;
              rsp_d.tcp_flag_bits = walk.flags;
              if (walk.short_tcp && !walk.frag) rsp_d.status = ST_RUNT;
            end else if (walk.nxt == PROTO_UDP) begin
              rsp_d.source_port = walk.src_port;
              rsp_d.dest_port   = walk.dst_port;
              if (walk.short_udp && !walk.frag) rsp_d.status = ST_RUNT;
            end
          end
          default: rsp_d.status = ST_BAD;
        endcase
        if (v6_bad) rsp_d.status = ST_BAD;
      end
      default: rsp_d.status = ST_BAD;
    endcase
    // a bad packet keeps only the family flag
    if (rsp_d.status == ST_BAD) begin
      rsp_d         = '0;
      rsp_d.status  = ST_BAD;
      rsp_d.is_ipv6 = in_q.family == FAM_V6;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (is_last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_last) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTHESIS
  a_result_from_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(is_last))
    else $error("result without a closing request");

  a_count_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_last |=> (cnt_q == '0))
    else $error("byte counter not restarted after packet end");

  a_count_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxPos)
    else $error("byte counter beyond capture limit");

  a_bad_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_BAD)
      |-> (out_q.protocol == '0 && out_q.source_port == '0 && out_q.total_length == '0))
    else $error("bad packet result carries fields");

  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.status == ST_OK || out_q.status == ST_BAD
                     || out_q.status == ST_RUNT))
    else $error("undefined status code");
`endif

endmodule

>>> sim/ip_transport_header_parser_core_tb.sv
// ip_transport_header_parser_core_tb: self-checking bench for the ip transport header parser,
// streams ipv4, ipv6 and broken packets a byte per request against a behavioural parser
// depends on ipthp_pkg and ip_transport_header_parser_core
module ip_transport_header_parser_core_tb
  import ipthp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPTURE_LIMIT = 65535;
  localparam int unsigned TARGET_BYTES  = 1650;
  localparam int unsigned MIN_PACKETS   = 36;
  localparam int unsigned MAX_IDLE      = 60;
  localparam int unsigned TAIL_CYCLES   = 16;
  localparam int unsigned PRINT_CAP     = 40;
  localparam logic [7:0]  PROTO_ICMP    = 8'd1;

  // one queued request plus a hold-off mark for the sender
  typedef struct packed {
    logic       drain_first;
    ipthp_req_t req;
  } stim_item_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  ipthp_req_t in_req_i    = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  ipthp_rsp_t out_rsp_o;

  stim_item_t  byte_stream[$];
  logic [7:0]  build_buf[$];
  logic [7:0]  capture_buf[$];
  ipthp_rsp_t  parsed_headers_due[$];
  stim_item_t  next_item;

  int unsigned bytes_queued    = 0;
  int unsigned packets_queued  = 0;
  int unsigned headers_checked = 0;
  int unsigned mismatch_count  = 0;
  longint unsigned cycle_count = 0;
  longint unsigned cycle_limit = 64'hFFFF_FFFF_FFFF;

  bit          req_taken  = 1'b0;
  int unsigned send_gap   = 0;
  int unsigned send_calm  = 0;
  int unsigned sink_stall = 0;
  int unsigned sink_calm  = 0;

  ip_transport_header_parser_core #(
    .MAX_CAPTURE_BYTES(CAPTURE_LIMIT)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // ---------------------------------------------------------------- parser model

  // bytes past the captured length read as zero
  function automatic logic [7:0] pkt_byte(input int unsigned idx);
    if (idx < capture_buf.size()) return capture_buf[idx];
    return 8'h00;
  endfunction

  function automatic logic [15:0] pkt_word(input int unsigned idx);
    return {pkt_byte(idx), pkt_byte(idx + 1)};
  endfunction

  function automatic ipthp_rsp_t decode_transport(input ipthp_rsp_t r, input int unsigned base,
                                                  input int unsigned rem, input bit frag,
                                                  input logic [7:0] proto);
    r.protocol = proto;
    r.status   = ST_OK;
    if (proto == PROTO_TCP) begin
      r.source_port   = pkt_word(base + TP_SPORT);
      r.dest_port     = pkt_word(base + TP_DPORT);
      r.tcp_flag_bits = pkt_byte(base + TP_FLAGS);
      if (rem < TCP_MIN && !frag) r.status = ST_RUNT;
    end else if (proto == PROTO_UDP) begin
      r.source_port = pkt_word(base + TP_SPORT);
      r.dest_port   = pkt_word(base + TP_DPORT);
      if (rem < UDP_MIN && !frag) r.status = ST_RUNT;
    end
    return r;
  endfunction

  function automatic ipthp_rsp_t parse_captured_packet(input logic [1:0] fam);
    ipthp_rsp_t  r;
    int unsigned cap, hlen, pos, rem, step, ext_len;
    logic [7:0]  b0, nxt;
    logic [15:0] off;
    bit          frag, done, v6;
    r    = '0;
    cap  = capture_buf.size();
    b0   = pkt_byte(0);
    frag = 1'b0;
    done = 1'b0;
    if (fam == FAM_V4) begin
      hlen = b0[3:0] * 4;
      if (cap < V4_MIN_HDR || cap < hlen || b0[7:4] != IPV4_VER) begin
        r.status = ST_BAD;
      end else begin
        r.total_length   = pkt_word(2);
        r.source_address = {pkt_word(12), pkt_word(14)};
        r.dest_address   = {pkt_word(16), pkt_word(18)};
        off              = pkt_word(6);
        frag             = (off[13:0] != 14'd0);
        r.is_fragment    = frag;
        if (off[12:0] != 13'd0) r.fragment_word = off;
        r = decode_transport(r, hlen, cap - hlen, frag, pkt_byte(9));
      end
    end else if (fam == FAM_V6) begin
      r.is_ipv6 = 1'b1;
      if (cap < V6_HDR || b0[7:4] != IPV6_VER) begin
        r.status = ST_BAD;
      end else begin
        nxt = pkt_byte(V6_NH_POS);
        pos = V6_HDR;
        rem = cap - V6_HDR;
        while (!done) begin
          if (nxt == NH_HOP || nxt == NH_ROUTE || nxt == NH_DSTOPT) begin
            ext_len = pkt_byte(pos + 1);
            step    = (ext_len + 1) * 8;
            if (rem < 2 || rem < step) begin
              // extension header cut short
              r.status      = ST_RUNT;
              r.is_fragment = frag;
              r.protocol    = nxt;
              done          = 1'b1;
            end else begin
              nxt = pkt_byte(pos);
              pos = pos + step;
              rem = rem - step;
            end
          end else if (nxt == NH_FRAG) begin
            frag          = 1'b1;
            r.is_fragment = 1'b1;
            r.protocol    = nxt;
            off           = pkt_word(pos + FRAG_OFF_POS);
            if (rem < FRAG_HDR_BYTES) begin
              r.status = ST_RUNT;
              done     = 1'b1;
            end else if (off[15:3] != 13'd0) begin
              // later fragment, no transport header to read
              r.status = ST_OK;
              done     = 1'b1;
            end else begin
              nxt = pkt_byte(pos);
              pos = pos + FRAG_HDR_BYTES;
              rem = rem - FRAG_HDR_BYTES;
            end
          end else begin
            r.is_fragment = frag;
            r             = decode_transport(r, pos, rem, frag, nxt);
            done          = 1'b1;
          end
        end
      end
    end else begin
      r.status = ST_BAD;
    end
    if (r.status == ST_BAD) begin
      v6        = r.is_ipv6;
      r         = '0;
      r.status  = ST_BAD;
      r.is_ipv6 = v6;
    end
    return r;
  endfunction

  task automatic absorb_byte(input ipthp_req_t req);
    if (capture_buf.size() < CAPTURE_LIMIT) capture_buf.push_back(req.data_byte);
    if (req.last_byte) begin
      parsed_headers_due.push_back(parse_captured_packet(req.family));
      capture_buf.delete();
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("packet %0d %s: got %h want %h", headers_checked, what, got, want);
  endtask

  task automatic compare_header(input ipthp_rsp_t got, input ipthp_rsp_t want);
    if (got.status !== want.status) report_mismatch("status", got.status, want.status);
    if (got.is_ipv6 !== want.is_ipv6) report_mismatch("is_ipv6", got.is_ipv6, want.is_ipv6);
    if (got.total_length !== want.total_length)
      report_mismatch("total_length", got.total_length, want.total_length);
    if (got.source_address !== want.source_address)
      report_mismatch("source_address", got.source_address, want.source_address);
    if (got.dest_address !== want.dest_address)
      report_mismatch("dest_address", got.dest_address, want.dest_address);
    if (got.is_fragment !== want.is_fragment)
      report_mismatch("is_fragment", got.is_fragment, want.is_fragment);
    if (got.fragment_word !== want.fragment_word)
      report_mismatch("fragment_word", got.fragment_word, want.fragment_word);
    if (got.protocol !== want.protocol)
      report_mismatch("protocol", got.protocol, want.protocol);
    if (got.source_port !== want.source_port)
      report_mismatch("source_port", got.source_port, want.source_port);
    if (got.dest_port !== want.dest_port)
      report_mismatch("dest_port", got.dest_port, want.dest_port);
    if (got.tcp_flag_bits !== want.tcp_flag_bits)
      report_mismatch("tcp_flag_bits", got.tcp_flag_bits, want.tcp_flag_bits);
  endtask

  // accepted requests feed the model, accepted results are checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      if (in_valid_i && in_ready_o) begin
        absorb_byte(in_req_i);
        req_taken = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        if (parsed_headers_due.size() == 0)
          report_mismatch("result with nothing due", out_rsp_o.status, '0);
        else
          compare_header(out_rsp_o, parsed_headers_due.pop_front());
        headers_checked++;
      end
    end
  end

  // ---------------------------------------------------------------- idling

  // mostly short pauses, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, MAX_IDLE);
  endfunction

  // sender: holds a request until taken, then maybe pauses
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !req_taken)) begin
      req_taken = 1'b0;
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap--;
      end else if (byte_stream.size() != 0 &&
                   !(byte_stream[0].drain_first && parsed_headers_due.size() != 0)) begin
        next_item = byte_stream.pop_front();
        in_req_i   <= next_item.req;
        in_valid_i <= 1'b1;
        if (send_calm > 0) begin
          send_calm--;
        end else if ($urandom_range(0, 199) == 0) begin
          send_calm = $urandom_range(100, 400);
        end else if ($urandom_range(0, 9) >= 6) begin
          send_gap = idle_len();
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls on the result channel
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sink_stall > 0) begin
        out_ready_i <= 1'b0;
        sink_stall--;
      end else begin
        out_ready_i <= 1'b1;
        if (sink_calm > 0) begin
          sink_calm--;
        end else if ($urandom_range(0, 99) < 2) begin
          sink_calm = $urandom_range(100, 300);
        end else if ($urandom_range(0, 99) < 30) begin
          sink_stall = idle_len();
        end
      end
    end
  end

  // ---------------------------------------------------------------- packet building

  task automatic add_random_bytes(input int unsigned n);
    repeat (n) build_buf.push_back(8'($urandom));
  endtask

  task automatic push_word(input logic [15:0] w);
    build_buf.push_back(w[15:8]);
    build_buf.push_back(w[7:0]);
  endtask

  function automatic logic [7:0] pick_transport();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return PROTO_TCP;
    if (r < 65) return PROTO_UDP;
    if (r < 80) return PROTO_ICMP;
    return 8'($urandom);
  endfunction

  task automatic add_transport(input logic [7:0] proto);
    if (proto == PROTO_TCP) add_random_bytes(20);
    else if (proto == PROTO_UDP || proto == PROTO_ICMP) add_random_bytes(8);
    else add_random_bytes($urandom_range(0, 8));
    add_random_bytes($urandom_range(0, 4));
  endtask

  // one packet in five is cut to a random length of at least one byte
  task automatic maybe_truncate();
    int unsigned keep;
    if ($urandom_range(0, 4) == 0) begin
      keep = $urandom_range(1, build_buf.size());
      while (build_buf.size() > keep) void'(build_buf.pop_back());
    end
  endtask

  task automatic build_ipv4_packet();
    int unsigned ihl, sel;
    logic [3:0]  ver;
    logic [15:0] frag_word;
    logic [7:0]  proto;
    sel = $urandom_range(0, 99);
    ihl = (sel < 80) ? 5 : (sel < 92) ? $urandom_range(6, 15) : $urandom_range(0, 4);
    ver = ($urandom_range(0, 9) != 0) ? IPV4_VER : 4'($urandom_range(0, 15));
    build_buf.push_back({ver, 4'(ihl)});
    add_random_bytes(1);
    push_word(16'($urandom));
    push_word(16'($urandom));
    case ($urandom_range(0, 3))
      0: frag_word = $urandom_range(0, 1) ? 16'h4000 : 16'h0000;
      1: frag_word = 16'h2000 | ($urandom_range(0, 1) ? 16'h0000 : 16'($urandom_range(1, 8191)));
      2: frag_word = {3'($urandom_range(0, 7)), 13'($urandom_range(1, 8191))};
      default: frag_word = 16'($urandom);
    endcase
    push_word(frag_word);
    add_random_bytes(1);
    proto = pick_transport();
    build_buf.push_back(proto);
    add_random_bytes(10);
    if (ihl > 5) add_random_bytes((ihl - 5) * 4);
    add_transport(proto);
    maybe_truncate();
  endtask

  task automatic build_ipv6_packet();
    int unsigned n_ext, nh_at, hdr_len, start, sel;
    logic [7:0]  kind;
    logic [15:0] off_word;
    build_buf.push_back({($urandom_range(0, 9) != 0) ? IPV6_VER : 4'($urandom_range(0, 15)),
                         4'($urandom_range(0, 15))});
    add_random_bytes(5);
    build_buf.push_back(8'h00);
    add_random_bytes(33);
    nh_at = V6_NH_POS;
    sel   = $urandom_range(0, 99);
    n_ext = (sel < 40) ? 0 : (sel < 70) ? 1 : (sel < 90) ? 2 : 3;
    repeat (n_ext) begin
      case ($urandom_range(0, 3))
        0:       kind = NH_HOP;
        1:       kind = NH_ROUTE;
        2:       kind = NH_DSTOPT;
        default: kind = NH_FRAG;
      endcase
      build_buf[nh_at] = kind;
      start = build_buf.size();
      if (kind == NH_FRAG) begin
        // mostly first fragments, sometimes a later one
        off_word = ($urandom_range(0, 4) != 0) ? {13'd0, 3'($urandom_range(0, 7))} :
                   {13'($urandom_range(1, 8191)), 3'($urandom_range(0, 7))};
        build_buf.push_back(8'h00);
        add_random_bytes(1);
        push_word(off_word);
        add_random_bytes(4);
      end else begin
        hdr_len = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 2) : $urandom_range(3, 255);
        build_buf.push_back(8'h00);
        build_buf.push_back(8'(hdr_len));
        add_random_bytes((hdr_len <= 2) ? (hdr_len + 1) * 8 - 2 : $urandom_range(0, 16));
      end
      nh_at = start;
    end
    kind = pick_transport();
    build_buf[nh_at] = kind;
    add_transport(kind);
    maybe_truncate();
  endtask

  // turns the built bytes into requests; family only counts on the last one
  task automatic queue_packet(input logic [1:0] fam, input bit drain, input bit counted);
    stim_item_t it;
    if (build_buf.size() == 0) build_buf.push_back(8'($urandom));
    foreach (build_buf[i]) begin
      it.drain_first   = drain && (i == 0);
      it.req.data_byte = build_buf[i];
      it.req.last_byte = (i == build_buf.size() - 1);
      it.req.family    = it.req.last_byte ? fam : 2'($urandom_range(0, 3));
      byte_stream.push_back(it);
    end
    if (counted) bytes_queued += build_buf.size();
    packets_queued++;
    build_buf.delete();
  endtask

  // ---------------------------------------------------------------- run control

  initial begin
    while (cycle_count < cycle_limit) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned sel;
    logic [1:0]  fam;
    bit          long_done;
    long_done = 1'b0;

    // lone bytes of an unknown family
    build_buf.push_back(8'h00);
    queue_packet(2'd2, 1'b0, 1'b1);
    build_buf.push_back(8'hFF);
    queue_packet(2'd3, 1'b0, 1'b1);
    // bare ipv4 header with every byte but version, ihl and protocol at ff, tcp with no bytes behind it
    build_buf.push_back({IPV4_VER, 4'd5});
    repeat (8) build_buf.push_back(8'hFF);
    build_buf.push_back(PROTO_TCP);
    repeat (10) build_buf.push_back(8'hFF);
    queue_packet(FAM_V4, 1'b0, 1'b1);

    while (bytes_queued < TARGET_BYTES || packets_queued < MIN_PACKETS) begin
      sel = $urandom_range(0, 99);
      if (sel < 42) begin
        build_ipv4_packet();
        fam = FAM_V4;
      end else if (sel < 84) begin
        build_ipv6_packet();
        fam = FAM_V6;
      end else if (sel < 92) begin
        add_random_bytes($urandom_range(1, 48));
        fam = 2'($urandom_range(2, 3));
      end else begin
        add_random_bytes($urandom_range(1, 48));
        fam = 2'($urandom_range(0, 1));
      end
      queue_packet(fam, (packets_queued % 12) == 0, 1'b1);
      if (!long_done && packets_queued >= 24) begin
        // long udp packet, payload well past every header
        build_buf.push_back({IPV4_VER, 4'd5});
        add_random_bytes(8);
        build_buf.push_back(PROTO_UDP);
        add_random_bytes(190);
        queue_packet(FAM_V4, 1'b1, 1'b0);
        long_done = 1'b1;
      end
    end

    cycle_limit = 4 * (longint'(byte_stream.size()) * (MAX_IDLE + 2) +
                       longint'(packets_queued) * (MAX_IDLE + 8)) + 10000;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (byte_stream.size() != 0 || in_valid_i) @(posedge clk_i);
    while (parsed_headers_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && parsed_headers_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
